// ===== design/ntc_pkg.sv =====
// Package for the NTC ADC-to-temperature median-average unit.
// Calibration table, window constants and state enum; no dependencies.
package ntc_pkg;
  localparam int Window = 10;
  localparam int TableEntries = 130;
  localparam int IdxW = 8;
  localparam int PtrW = 4;
  localparam int TempOffset = 30;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SEG, S_START, S_DIV, S_WRITE, S_SCAN, S_LAST, S_TRIM, S_AVG, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [11:0] divisor;
  } div_req_t;

  function automatic logic [11:0] rom_read(input logic [IdxW-1:0] i);
    logic [11:0] t [0:129];
    t = '{
      12'd3847, 12'd3833, 12'd3819, 12'd3804, 12'd3789, 12'd3773, 12'd3757, 12'd3740,
      12'd3722, 12'd3703, 12'd3684, 12'd3664, 12'd3643, 12'd3622, 12'd3599, 12'd3576,
      12'd3552, 12'd3527, 12'd3502, 12'd3475, 12'd3448, 12'd3420, 12'd3390, 12'd3360,
      12'd3329, 12'd3298, 12'd3265, 12'd3231, 12'd3197, 12'd3162, 12'd3123, 12'd3089,
      12'd3051, 12'd3013, 12'd2973, 12'd2933, 12'd2893, 12'd2852, 12'd2810, 12'd2767,
      12'd2720, 12'd2681, 12'd2637, 12'd2593, 12'd2548, 12'd2503, 12'd2458, 12'd2412,
      12'd2367, 12'd2321, 12'd2275, 12'd2230, 12'd2184, 12'd2138, 12'd2093, 12'd2048,
      12'd2002, 12'd1958, 12'd1913, 12'd1869, 12'd1825, 12'd1782, 12'd1739, 12'd1697,
      12'd1655, 12'd1614, 12'd1573, 12'd1533, 12'd1494, 12'd1455, 12'd1417, 12'd1380,
      12'd1343, 12'd1307, 12'd1272, 12'd1237, 12'd1203, 12'd1170, 12'd1138, 12'd1106,
      12'd1081, 12'd1045, 12'd1016, 12'd987,  12'd959,  12'd932,  12'd905,  12'd879,
      12'd854,  12'd829,  12'd806,  12'd782,  12'd760,  12'd738,  12'd716,  12'd696,
      12'd675,  12'd656,  12'd637,  12'd618,  12'd600,  12'd583,  12'd566,  12'd550,
      12'd534,  12'd518,  12'd503,  12'd489,  12'd475,  12'd461,  12'd448,  12'd435,
      12'd422,  12'd410,  12'd398,  12'd387,  12'd376,  12'd365,  12'd355,  12'd345,
      12'd335,  12'd326,  12'd316,  12'd308,  12'd299,  12'd290,  12'd283,  12'd274,
      12'd267,  12'd259};
    if (i >= IdxW'(TableEntries)) return 12'd0;
    return t[i];
  endfunction
endpackage

// ===== design/ntc_div.sv =====
// Restoring divider for the interpolation fraction and the trimmed average,
// one quotient bit per cycle. Depends on ntc_pkg.
module ntc_div import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        busy,
  output logic [15:0] quot
);
  logic [15:0] rem;
  logic [15:0] q;
  logic [11:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic [15:0] remsh;

  assign remsh = {rem[14:0], q[15]};
  assign trial = {1'b0, remsh} - {5'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      rem <= '0;
      q <= req.dividend;
      dvs <= req.divisor;
      cnt <= 5'd16;
    end else if (cnt != 0) begin
      if (!trial[16]) begin
        rem <= trial[15:0];
        q <= {q[14:0], 1'b1};
      end else begin
        rem <= remsh;
        q <= {q[14:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
    end
  end
  assign busy = (cnt != 0);
  assign quot = q;
endmodule

// ===== design/ntc_ring.sv =====
// Sample ring memory, one synchronous write and one registered read port.
// Depends on ntc_pkg.
module ntc_ring import ntc_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [PtrW-1:0] waddr,
  input  logic [11:0]     wdata,
  input  logic [PtrW-1:0] raddr,
  output logic [11:0]     rdata
);
  logic [11:0] mem [0:Window-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/ntc_adc_to_temp_median_avg_unit.sv =====
// NTC ADC-to-temperature unit with median-average filter, top level.
// Uses ntc_pkg, ntc_div and ntc_ring.
// Each input transfer carries one 12-bit ADC sample; each output transfer returns that
// sample's temperature and the filtered temperature, both in signed tenths of a degree.
// One sample is in flight at a time: accept, binary table search, segment lookup,
// interpolation divide, ring write, ring scan, trimmed sum (total minus min and max),
// average divide and output. The result register frees the input side; a stalled
// output only holds the next result in its output cycle.
module ntc_adc_to_temp_median_avg_unit import ntc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        adc_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] sample_temp_tenths,
  output logic signed [11:0] filtered_temp_tenths
);
  state_t state, state_next;
  logic [11:0] adc;
  logic [IdxW-1:0] lo, hx, mid, hit;
  logic [11:0] upper, lower, span;
  logic signed [11:0] tval, first, favg, vmin, vmax, rval;
  logic [PtrW-1:0] wp, cnt, ridx;
  logic rvalid, neg;
  logic signed [15:0] sum, trim;
  logic [15:0] mag;
  div_req_t dreq;
  logic dbusy;
  logic [15:0] dquot;
  logic [11:0] rdata;
  logic we, load, out_valid_next;

  ntc_div u_div (.clk, .rst, .req(dreq), .busy(dbusy), .quot(dquot));
  ntc_ring u_ring (.clk, .we, .waddr(wp), .wdata(tval), .raddr(ridx), .rdata);

  assign mid = IdxW'(({1'b0, lo} + {1'b0, hx}) >> 1);
  assign in_stall = (state != S_IDLE);
  assign span = upper - lower;
  assign rval = $signed(rdata);
  assign trim = sum - 16'(vmin) - 16'(vmax);
  assign mag = trim[15] ? $unsigned(-trim) : $unsigned(trim);
  assign we = (state == S_WRITE);

  always_comb begin
    state_next = state;
    dreq = '0;
    load = 1'b0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE:   if (in_valid && !in_stall) state_next = S_SEARCH;
      S_SEARCH: if (lo >= hx) state_next = S_SEG;
      S_SEG:    state_next = S_START;
      S_START: begin
        if (hit != '0 && span != '0) begin
          dreq.start = 1'b1;
          dreq.dividend = 16'(upper - adc) * 16'd10;
          dreq.divisor = span;
          state_next = S_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV:    if (!dbusy) state_next = S_WRITE;
      S_WRITE:  state_next = (cnt >= PtrW'(2)) ? S_SCAN : S_OUT;
      S_SCAN:   if (ridx == cnt - 1'b1) state_next = S_LAST;
      S_LAST:   state_next = S_TRIM;
      S_TRIM: begin
        dreq.start = 1'b1;
        dreq.dividend = mag;
        dreq.divisor = {8'd0, cnt} - 12'd2;
        state_next = S_AVG;
      end
      S_AVG:    if (!dbusy) state_next = S_OUT;
      S_OUT: begin
        if (!(out_valid && out_stall)) begin
          load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          adc <= adc_sample;
          lo <= '0;
          hx <= IdxW'(TableEntries);
        end
        S_SEARCH: begin
          if (lo < hx) begin
            if (adc >= rom_read(mid)) hx <= mid;
            else lo <= mid + 1'b1;
          end else begin
            hit <= (lo == IdxW'(TableEntries)) ? IdxW'(TableEntries - 1) : lo;
          end
        end
        S_SEG: begin
          upper <= rom_read(hit - 1'b1);
          lower <= rom_read(hit);
          tval <= (hit == '0) ? 12'(-(TempOffset * 10))
                  : ($signed({4'd0, hit}) - 12'(TempOffset + 1)) * 12'sd10;
        end
        S_DIV: if (!dbusy) tval <= tval + $signed(dquot[11:0]);
        S_WRITE: begin
          if (cnt == 0) first <= tval;
          wp <= (wp == PtrW'(Window - 1)) ? '0 : wp + 1'b1;
          if (cnt != PtrW'(Window)) cnt <= cnt + 1'b1;
          ridx <= '0;
        end
        S_SCAN: ridx <= ridx + 1'b1;
        S_TRIM: neg <= trim[15];
        S_AVG: if (!dbusy) favg <= neg ? -$signed(dquot[11:0]) : $signed(dquot[11:0]);
        S_OUT: if (load) begin
          sample_temp_tenths <= tval;
          filtered_temp_tenths <= (cnt < PtrW'(3)) ? first : favg;
        end
        default: ;
      endcase
    end
  end

  // ring read data arrives in the cycle after its scan address
  always_ff @(posedge clk) begin
    if (rst) rvalid <= 1'b0;
    else rvalid <= (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      sum <= '0;
      vmin <= 12'sh7ff;
      vmax <= 12'sh800;
    end else if (rvalid) begin
      sum <= sum + 16'(rval);
      if (rval < vmin) vmin <= rval;
      if (rval > vmax) vmax <= rval;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_temp_tenths)
      && $stable(filtered_temp_tenths));
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= PtrW'(Window));
  a_wp_range: assert property (@(posedge clk) disable iff (rst) wp < PtrW'(Window));
  a_div_idle: assert property (@(posedge clk) disable iff (rst) dreq.start |-> !dbusy);
  a_scan_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ridx < cnt);
endmodule
